// File: rtl/itrt_pkg.sv
package itrt_pkg;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int DIGIT_W        = 4;
    localparam int MAG_W          = 64;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd3;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

    localparam int MODE_UNSIGNED = 0;
    localparam int MODE_LOWER    = 1;

    typedef struct packed {
        logic [MAG_W-1:0]   value_bits;
        logic [RADIX_W-1:0] radix;
        logic [1:0]         mode_flags;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_STEP,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic rd;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic mag_zero;
        logic cnt_zero;
        logic idx_zero;
        logic neg;
        logic out_free;
    } t_sts;

    function automatic logic [CHAR_W-1:0] itrt_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + d_ext;
        end else if (lower) begin
            return ASCII_LOWER_A + d_ext - 7'd10;
        end else begin
            return ASCII_UPPER_A + d_ext - 7'd10;
        end
    endfunction

endpackage

// File: rtl/itrt_ram.sv
module itrt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/itrt_ctrl.sv
module itrt_ctrl import itrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                // at least one digit is always produced, even for zero
                if (!i_sts.cnt_zero && i_sts.mag_zero) begin
                    n_state = i_sts.neg ? ST_SIGN : ST_READ;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.idx_zero) begin
                    n_state = ST_PREP;
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    n_state          = i_sts.cnt_zero ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/itrt_dpath.sv
module itrt_dpath import itrt_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    logic [MAG_W-1:0]   r_mag,  n_mag;
    logic [DIGIT_W-1:0] r_rem,  n_rem;
    logic [2:0]         r_idx,  n_idx;
    logic [RADIX_W-1:0] r_base, n_base;
    logic               r_lower, n_lower;
    logic               r_neg,  n_neg;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word,  n_out_word;

    logic [7:0]         s_byte;
    logic [7:0]         s_quot;
    logic [DIGIT_W-1:0] s_rem;
    logic [2:0]         s_top;
    logic               s_wr_en;
    logic [DIGIT_W-1:0] s_rd_data;
    logic [CNT_W-1:0]   s_cnt_dec;

    // one quotient byte per cycle, restoring, msb first
    always_comb begin
        logic [RADIX_W-1:0] v_t;
        s_byte = r_mag[{r_idx, 3'b000} +: 8];
        s_rem  = r_rem;
        s_quot = '0;
        for (int i = 7; i >= 0; i--) begin
            v_t = {s_rem, s_byte[i]};
            if (v_t >= r_base) begin
                s_quot[i] = 1'b1;
                v_t       = v_t - r_base;
            end
            s_rem = v_t[DIGIT_W-1:0];
        end
    end

    // highest nonzero byte; leading zero bytes divide to zero
    always_comb begin
        s_top = '0;
        for (int k = 0; k < 8; k++) begin
            if (r_mag[k*8 +: 8] != 8'd0) begin
                s_top = 3'(k);
            end
        end
    end

    assign s_wr_en   = i_cmd.step && (r_idx == 3'd0) && (r_cnt < CNT_W'(MAX_DIGITS));
    assign s_cnt_dec = r_cnt - CNT_W'(1);

    itrt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (r_cnt[ADDR_W-1:0]),
        .i_wr_data (s_rem),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (s_cnt_dec[ADDR_W-1:0]),
        .o_rd_data (s_rd_data)
    );

    always_comb begin
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_base      = r_base;
        n_lower     = r_lower;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (i_cmd.load) begin
            if (i_in_word.radix < RADIX_MIN) begin
                n_base = RADIX_MIN;
            end else if (i_in_word.radix > RADIX_MAX) begin
                n_base = RADIX_MAX;
            end else begin
                n_base = i_in_word.radix;
            end
            n_neg   = !i_in_word.mode_flags[MODE_UNSIGNED] && i_in_word.value_bits[MAG_W-1];
            n_mag   = n_neg ? (MAG_W'(0) - i_in_word.value_bits) : i_in_word.value_bits;
            n_lower = i_in_word.mode_flags[MODE_LOWER];
            n_cnt   = '0;
        end

        if (i_cmd.prep) begin
            n_idx = s_top;
            n_rem = '0;
        end

        if (i_cmd.step) begin
            n_mag[{r_idx, 3'b000} +: 8] = s_quot;
            n_rem                       = s_rem;
            n_idx                       = r_idx - 3'd1;
            if (s_wr_en) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end

        if (i_cmd.rd) begin
            n_cnt = s_cnt_dec;
        end

        // drop the word once taken, load a new one when told
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit_sign) begin
            n_out_valid          = 1'b1;
            n_out_word.character = ASCII_MINUS;
            n_out_word.last      = 1'b0;
        end else if (i_cmd.emit_digit) begin
            n_out_valid          = 1'b1;
            n_out_word.character = itrt_char(s_rd_data, r_lower);
            n_out_word.last      = (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_idx      <= n_idx;
        r_base     <= n_base;
        r_lower    <= n_lower;
        r_out_word <= n_out_word;
    end

    assign o_sts.mag_zero = (r_mag == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.idx_zero = (r_idx == 3'd0);
    assign o_sts.neg      = r_neg;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: rtl/integer_to_radix_text_core.sv
// Integer to text converter.
// Input channel: i_in_valid / o_in_stall carry one word (64-bit value, base
// 3..16, mode bits unsigned and lowercase). A base outside 3..16 is clamped.
// Output channel: o_out_valid / i_out_stall carry one ASCII character per
// word, most significant first, with a leading '-' for negative signed
// values; last marks the final character. Zero gives a single '0'.
// One number is converted at a time: o_in_stall is low only while idle.
// Digits come from a shared divider that produces one quotient byte per
// cycle, starting at the highest nonzero byte of the remaining magnitude.
// Each digit takes a prep step, then one divide step per significant byte
// left (1..8 bytes). Digits then go out through a digit store read and
// then the output register; the sign goes straight to the output register.
// A new number is accepted while the last character still waits in the
// output register.
// Reset (synchronous, active low) drops any number in progress and clears
// o_out_valid; the digit store needs no clearing. While i_out_stall is high
// and a word is valid, the output word holds and the emit phase pauses.
module integer_to_radix_text_core import itrt_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cmd s_cmd;
    t_sts s_sts;

    itrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    itrt_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// File: rtl/itrt_checker.sv
module itrt_checker import itrt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // stalled word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // stalled word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // an accepted number blocks the input; checked right after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    // a sign never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.character == ASCII_MINUS) |-> !o_out_word.last)
        else $error("minus sign flagged as last");

    // no character is offered in the cycle after an input accept made with the output empty
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("character emitted before any digit was computed");

endmodule

bind integer_to_radix_text_core itrt_checker u_itrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
